@@ rtl/core/tlsi_pkg.sv @@
package tlsi_pkg;

	// default sizes of the step counters and the position counters
	localparam int STEP_BITS_DEF = 24;
	localparam int POS_BITS_DEF  = 32;

	// field widths of the channels
	localparam int MOVE_BITS   = 25;
	localparam int DELAY_BITS  = 16;
	localparam int RAMP_BITS   = 24;
	localparam int HALF_BITS   = 20;
	localparam int OUT_POS_BITS = 32;
	localparam int FACTOR_BITS = 4;

	// ramp unit sizes: k and the ramp length share one width, the gap is a half period
	localparam int RAMP_K_BITS   = RAMP_BITS;
	localparam int RAMP_D_BITS   = HALF_BITS;
	localparam int RAMP_CNT_BITS = $clog2(RAMP_K_BITS);

	// operation codes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// configuration registers
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_START_FACTOR = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_START    = 1'd1;
	localparam logic [FACTOR_BITS-1:0]    START_FACTOR_RST = 4'd5;
	localparam logic [DELAY_BITS-1:0]     MIN_START_RST    = 16'd500;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_RAMP,
		TOP_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		RAMP_IDLE,
		RAMP_SQUARE,
		RAMP_SCALE,
		RAMP_DIVIDE,
		RAMP_DONE
	} ramp_state_t;

	typedef struct packed {
		logic                   start;
		logic [RAMP_K_BITS-1:0] k;
		logic [RAMP_D_BITS-1:0] gap;
		logic [RAMP_K_BITS-1:0] span;
	} ramp_req_t;

	typedef struct packed {
		logic                   done;
		logic [RAMP_D_BITS-1:0] term;
	} ramp_rsp_t;

endpackage

@@ rtl/core/two_axis_linear_step_interpolator.sv @@
// Two-axis linear step interpolator. A load request (operation 0) sets up a move from signed
// X and Y step counts, a cruise half period and a ramp length; each advance request
// (operation 1) steps the dominant axis, steps the other axis by Bresenham error, updates the
// signed positions and gives the half period of a quadratic ramp from the start delay
// max(start_factor * cruise, min_start_delay) to cruise, down or up, and back near the end.
// One request is in work at a time and every request gives exactly one result. A load, an
// idle advance or a cruise step goes straight to the result register, where it waits until
// it is taken. A step inside a ramp first waits for the ramp term floor(k*k*gap / ramp^2)
// from a bit-serial unit that squares k and the ramp length, scales by the gap and divides
// one quotient bit a cycle. Configuration is written through cfg_we, cfg_index and cfg_data.
module two_axis_linear_step_interpolator #(
	parameter int STEP_BITS = tlsi_pkg::STEP_BITS_DEF,
	parameter int POS_BITS  = tlsi_pkg::POS_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [tlsi_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [tlsi_pkg::CFG_DATA_BITS-1:0]        cfg_data,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic                                      operation,
	input  logic signed [tlsi_pkg::MOVE_BITS-1:0]     x_move_steps,
	input  logic signed [tlsi_pkg::MOVE_BITS-1:0]     y_move_steps,
	input  logic [tlsi_pkg::DELAY_BITS-1:0]           cruise_delay,
	input  logic [tlsi_pkg::RAMP_BITS-1:0]            ramp_steps,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic                                      x_pulse,
	output logic                                      y_pulse,
	output logic                                      x_dir,
	output logic                                      y_dir,
	output logic [tlsi_pkg::HALF_BITS-1:0]            half_period,
	output logic                                      last_step,
	output logic signed [tlsi_pkg::OUT_POS_BITS-1:0]  x_position,
	output logic signed [tlsi_pkg::OUT_POS_BITS-1:0]  y_position,
	output logic                                      idle_error
);

	localparam int S  = STEP_BITS;
	localparam int MB = tlsi_pkg::MOVE_BITS;
	localparam int HB = tlsi_pkg::HALF_BITS;
	localparam int DB = tlsi_pkg::DELAY_BITS;
	localparam int RB = tlsi_pkg::RAMP_BITS;
	localparam logic [31:0] STEP_CAP = (32'd1 << S) - 32'd1;

	function automatic logic [S-1:0] sat_mag(input logic [MB-1:0] raw);
		logic [MB-1:0] abs_v;
		logic [31:0]   wide;
		abs_v = raw[MB-1] ? (~raw + MB'(1)) : raw;
		wide  = 32'(abs_v);
		if (wide > STEP_CAP) wide = STEP_CAP;
		return wide[S-1:0];
	endfunction

	tlsi_pkg::top_state_t state_q, state_d;
	tlsi_pkg::ramp_req_t  ramp_req;
	tlsi_pkg::ramp_rsp_t  ramp_rsp;

	logic [tlsi_pkg::FACTOR_BITS-1:0] start_factor_q;
	logic [DB-1:0]                    min_start_q;

	logic                  move_active_q, x_major_q;
	logic [S-1:0]          major_q, minor_q, index_q;
	logic signed [S+1:0]   err_q;
	logic [1:0]            dir_q;
	logic [DB-1:0]         cruise_q;
	logic [HB-1:0]         start_q;
	logic [RB-1:0]         ramp_q;
	logic [POS_BITS-1:0]   x_count_q, y_count_q;

	logic                  x_pulse_q, y_pulse_q, last_q, idle_q;
	logic [HB-1:0]         half_q;

	logic                  accept, is_load, do_step, need_ramp;
	logic [S-1:0]          x_mag, y_mag, major_new, minor_new, k_full, index_next;
	logic                  x_major_new;
	logic [HB-1:0]         start_prod, start_new, gap, cruise_ext, ramp_half;
	logic                  in_accel, in_decel, start_high;
	logic signed [S+1:0]   err_sub, err_next;
	logic                  minor_fire, step_x, step_y;
	logic [63:0]           x_ext, y_ext;

	assign accept  = in_valid && !in_stall;
	assign is_load = (operation == tlsi_pkg::OP_LOAD);
	assign do_step = !is_load && move_active_q;

	// load side
	always_comb begin
		x_mag       = sat_mag(x_move_steps);
		y_mag       = sat_mag(y_move_steps);
		x_major_new = x_mag >= y_mag;
		major_new   = x_major_new ? x_mag : y_mag;
		minor_new   = x_major_new ? y_mag : x_mag;
		start_prod  = HB'(start_factor_q) * HB'(cruise_delay);
		start_new   = (start_prod < HB'(min_start_q)) ? HB'(min_start_q) : start_prod;
	end

	// step side
	always_comb begin
		cruise_ext = HB'(cruise_q);
		start_high = start_q >= cruise_ext;
		gap        = start_high ? (start_q - cruise_ext) : (cruise_ext - start_q);
		in_accel   = 32'(index_q) < 32'(ramp_q);
		in_decel   = (33'(index_q) + 33'(ramp_q)) >= 33'(major_q);
		need_ramp  = do_step && (in_accel || in_decel);
		k_full     = in_accel ? index_q : (major_q - index_q);
		err_sub    = err_q - signed'({2'b00, minor_q});
		minor_fire = err_sub[S+1];
		err_next   = minor_fire ? (err_sub + signed'({2'b00, major_q})) : err_sub;
		step_x     = x_major_q || minor_fire;
		step_y     = !x_major_q || minor_fire;
		index_next = index_q + S'(1);
		ramp_half  = start_high ? (start_q - ramp_rsp.term) : (start_q + ramp_rsp.term);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlsi_pkg::TOP_IDLE: if (accept) state_d = need_ramp ? tlsi_pkg::TOP_RAMP : tlsi_pkg::TOP_OUT;
			tlsi_pkg::TOP_RAMP: if (ramp_rsp.done) state_d = tlsi_pkg::TOP_OUT;
			tlsi_pkg::TOP_OUT:  if (!out_stall) state_d = tlsi_pkg::TOP_IDLE;
			default:            state_d = tlsi_pkg::TOP_IDLE;
		endcase
	end

	always_comb begin
		in_stall       = (state_q != tlsi_pkg::TOP_IDLE);
		out_valid      = (state_q == tlsi_pkg::TOP_OUT);
		ramp_req.start = (state_q == tlsi_pkg::TOP_IDLE) && accept && need_ramp;
		ramp_req.k     = tlsi_pkg::RAMP_K_BITS'(k_full);
		ramp_req.gap   = gap;
		ramp_req.span  = ramp_q;
	end

	tlsi_ramp u_ramp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ramp_req),
		.rsp    (ramp_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tlsi_pkg::TOP_IDLE;
			start_factor_q <= tlsi_pkg::START_FACTOR_RST;
			min_start_q    <= tlsi_pkg::MIN_START_RST;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					tlsi_pkg::CFG_START_FACTOR: start_factor_q <= cfg_data[tlsi_pkg::FACTOR_BITS-1:0];
					tlsi_pkg::CFG_MIN_START:    min_start_q    <= cfg_data[DB-1:0];
					default: ;
				endcase
			end
		end
	end

	// move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_active_q <= 1'b0;
			x_major_q     <= 1'b0;
			major_q       <= '0;
			minor_q       <= '0;
			index_q       <= '0;
			err_q         <= '0;
			dir_q         <= '0;
			cruise_q      <= '0;
			start_q       <= '0;
			ramp_q        <= '0;
			x_count_q     <= '0;
			y_count_q     <= '0;
		end else if (accept) begin
			if (is_load) begin
				dir_q         <= {!y_move_steps[MB-1], !x_move_steps[MB-1]};
				x_major_q     <= x_major_new;
				major_q       <= major_new;
				minor_q       <= minor_new;
				err_q         <= signed'({2'b00, major_new} >> 1);
				index_q       <= '0;
				cruise_q      <= cruise_delay;
				ramp_q        <= ramp_steps;
				start_q       <= start_new;
				move_active_q <= (major_new != '0);
			end else if (move_active_q) begin
				err_q   <= err_next;
				index_q <= index_next;
				if (index_next >= major_q) move_active_q <= 1'b0;
				if (step_x) x_count_q <= dir_q[0] ? x_count_q + POS_BITS'(1) : x_count_q - POS_BITS'(1);
				if (step_y) y_count_q <= dir_q[1] ? y_count_q + POS_BITS'(1) : y_count_q - POS_BITS'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			x_pulse_q <= do_step && step_x;
			y_pulse_q <= do_step && step_y;
			idle_q    <= !is_load && !move_active_q;
			last_q    <= is_load ? (major_new == '0) : (do_step && (index_next >= major_q));
			half_q    <= do_step ? cruise_ext : '0;
		end else if (state_q == tlsi_pkg::TOP_RAMP && ramp_rsp.done) begin
			half_q <= ramp_half;
		end
	end

	always_comb begin
		x_ext       = 64'(signed'(x_count_q));
		y_ext       = 64'(signed'(y_count_q));
		x_pulse     = x_pulse_q;
		y_pulse     = y_pulse_q;
		x_dir       = dir_q[0];
		y_dir       = dir_q[1];
		half_period = half_q;
		last_step   = last_q;
		idle_error  = idle_q;
		x_position  = signed'(x_ext[tlsi_pkg::OUT_POS_BITS-1:0]);
		y_position  = signed'(y_ext[tlsi_pkg::OUT_POS_BITS-1:0]);
	end

endmodule

@@ rtl/core/tlsi_ramp.sv @@
module tlsi_ramp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlsi_pkg::ramp_req_t  req,
	output tlsi_pkg::ramp_rsp_t  rsp
);

	localparam int K = tlsi_pkg::RAMP_K_BITS;
	localparam int D = tlsi_pkg::RAMP_D_BITS;
	localparam int N = 2 * K + D;
	localparam int C = tlsi_pkg::RAMP_CNT_BITS;
	localparam logic [C-1:0] SQUARE_LAST = C'(K - 1);
	localparam logic [C-1:0] BIT_LAST    = C'(D - 1);

	tlsi_pkg::ramp_state_t state_q, state_d;
	logic [C-1:0]   cnt_q;
	logic [K-1:0]   k_q, r_q;
	logic [2*K-1:0] ksq_q, rsq_q;
	// high part is the running sum or remainder, low part the multiplier or quotient
	logic [N-1:0]   num_q;

	logic [K:0]     ksq_sum, rsq_sum;
	logic [2*K:0]   scale_sum;
	logic [2*K:0]   div_trial, div_diff;
	logic           div_fit;
	logic [2*K-1:0] div_rem;

	always_comb begin
		ksq_sum   = {1'b0, ksq_q[2*K-1:K]} + {1'b0, (ksq_q[0] ? k_q : K'(0))};
		rsq_sum   = {1'b0, rsq_q[2*K-1:K]} + {1'b0, (rsq_q[0] ? r_q : K'(0))};
		scale_sum = {1'b0, num_q[N-1:D]} + {1'b0, (num_q[0] ? ksq_q : (2*K)'(0))};
		div_trial = {num_q[N-1:D], num_q[D-1]};
		div_diff  = div_trial - {1'b0, rsq_q};
		div_fit   = div_trial >= {1'b0, rsq_q};
		div_rem   = div_fit ? div_diff[2*K-1:0] : div_trial[2*K-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlsi_pkg::RAMP_IDLE:   if (req.start) state_d = tlsi_pkg::RAMP_SQUARE;
			tlsi_pkg::RAMP_SQUARE: if (cnt_q == SQUARE_LAST) state_d = tlsi_pkg::RAMP_SCALE;
			tlsi_pkg::RAMP_SCALE:  if (cnt_q == BIT_LAST) state_d = tlsi_pkg::RAMP_DIVIDE;
			tlsi_pkg::RAMP_DIVIDE: if (cnt_q == BIT_LAST) state_d = tlsi_pkg::RAMP_DONE;
			tlsi_pkg::RAMP_DONE:   state_d = tlsi_pkg::RAMP_IDLE;
			default:               state_d = tlsi_pkg::RAMP_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = (state_q == tlsi_pkg::RAMP_DONE);
		rsp.term = num_q[D-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlsi_pkg::RAMP_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + C'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tlsi_pkg::RAMP_IDLE && req.start) begin
			k_q   <= req.k;
			r_q   <= req.span;
			ksq_q <= {K'(0), req.k};
			rsq_q <= {K'(0), req.span};
			num_q <= {(2*K)'(0), req.gap};
		end else if (state_q == tlsi_pkg::RAMP_SQUARE) begin
			ksq_q <= {ksq_sum, ksq_q[K-1:1]};
			rsq_q <= {rsq_sum, rsq_q[K-1:1]};
		end else if (state_q == tlsi_pkg::RAMP_SCALE) begin
			num_q <= {scale_sum, num_q[D-1:1]};
		end else if (state_q == tlsi_pkg::RAMP_DIVIDE) begin
			// restoring division, the quotient bit shifts into the low end
			num_q <= {div_rem, num_q[D-2:0], div_fit};
		end
	end

endmodule

@@ tb/sv/step_move_checker.sv @@
module step_move_checker (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [tlsi_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [tlsi_pkg::CFG_DATA_BITS-1:0]        cfg_data,
	input  logic                                      in_valid,
	input  logic                                      in_stall,
	input  logic                                      operation,
	input  logic signed [tlsi_pkg::MOVE_BITS-1:0]     x_move_steps,
	input  logic signed [tlsi_pkg::MOVE_BITS-1:0]     y_move_steps,
	input  logic [tlsi_pkg::DELAY_BITS-1:0]           cruise_delay,
	input  logic [tlsi_pkg::RAMP_BITS-1:0]            ramp_steps,
	input  logic                                      out_valid,
	input  logic                                      out_stall,
	input  logic                                      x_pulse,
	input  logic                                      y_pulse,
	input  logic                                      x_dir,
	input  logic                                      y_dir,
	input  logic [tlsi_pkg::HALF_BITS-1:0]            half_period,
	input  logic                                      last_step,
	input  logic signed [tlsi_pkg::OUT_POS_BITS-1:0]  x_position,
	input  logic signed [tlsi_pkg::OUT_POS_BITS-1:0]  y_position,
	input  logic                                      idle_error,
	output int                                        errors,
	output int                                        outstanding
);
	import tlsi_pkg::*;

	localparam int     CNT_BITS  = STEP_BITS_DEF;
	localparam longint STEP_CAP  = (longint'(1) << STEP_BITS_DEF) - 1;

	typedef struct packed {
		logic                    x_pulse;
		logic                    y_pulse;
		logic                    x_dir;
		logic                    y_dir;
		logic [HALF_BITS-1:0]    half_period;
		logic                    last_step;
		logic [OUT_POS_BITS-1:0] x_position;
		logic [OUT_POS_BITS-1:0] y_position;
		logic                    idle_error;
	} step_result_t;

	// register copies
	logic [FACTOR_BITS-1:0] start_factor;
	logic [DELAY_BITS-1:0]  min_start;

	// move state
	logic                   move_active;
	logic                   x_major;
	logic [CNT_BITS-1:0]    major_total;
	logic [CNT_BITS-1:0]    minor_total;
	logic signed [CNT_BITS+1:0] step_error;
	logic [CNT_BITS-1:0]    step_index;
	logic                   x_fwd;
	logic                   y_fwd;
	logic [DELAY_BITS-1:0]  cruise_half;
	logic [HALF_BITS-1:0]   start_half;
	logic [RAMP_BITS-1:0]   ramp_len;
	logic [OUT_POS_BITS-1:0] x_count;
	logic [OUT_POS_BITS-1:0] y_count;

	step_result_t pending_steps[$];

	function automatic logic [CNT_BITS-1:0] clamp_count(logic signed [MOVE_BITS-1:0] v);
		longint m;
		m = v;
		if (m < 0)
			m = -m;
		if (m > STEP_CAP)
			m = STEP_CAP;
		return m[CNT_BITS-1:0];
	endfunction

	// floor(k*k*gap / ramp^2), wide enough that nothing overflows
	function automatic logic [HALF_BITS-1:0] ramp_shift(logic [RAMP_BITS-1:0] k,
			logic [HALF_BITS-1:0] gap);
		logic [127:0] num;
		logic [127:0] den;
		num = 128'(k) * 128'(k) * 128'(gap);
		den = 128'(ramp_len) * 128'(ramp_len);
		return HALF_BITS'(num / den);
	endfunction

	function automatic logic [HALF_BITS-1:0] half_period_at(logic [RAMP_BITS-1:0] k);
		if (start_half >= HALF_BITS'(cruise_half))
			return start_half - ramp_shift(k, start_half - HALF_BITS'(cruise_half));
		return start_half + ramp_shift(k, HALF_BITS'(cruise_half) - start_half);
	endfunction

	function automatic step_result_t next_step_result(logic op,
			logic signed [MOVE_BITS-1:0] xs, logic signed [MOVE_BITS-1:0] ys,
			logic [DELAY_BITS-1:0] cruise, logic [RAMP_BITS-1:0] ramp);
		step_result_t         r;
		logic [CNT_BITS-1:0]  xm;
		logic [CNT_BITS-1:0]  ym;
		logic [HALF_BITS-1:0] s;
		logic                 minor_hit;
		r = '0;
		if (op == OP_LOAD) begin
			xm = clamp_count(xs);
			ym = clamp_count(ys);
			x_fwd = !xs[MOVE_BITS-1];
			y_fwd = !ys[MOVE_BITS-1];
			x_major = xm >= ym;
			major_total = x_major ? xm : ym;
			minor_total = x_major ? ym : xm;
			step_error = $signed({2'b00, major_total >> 1});
			step_index = '0;
			cruise_half = cruise;
			ramp_len = ramp;
			s = HALF_BITS'(start_factor) * HALF_BITS'(cruise);
			if (s < HALF_BITS'(min_start))
				s = HALF_BITS'(min_start);
			start_half = s;
			move_active = major_total != 0;
			r.last_step = !move_active;
		end else if (!move_active) begin
			r.idle_error = 1'b1;
		end else begin
			if (step_index < ramp_len)
				r.half_period = half_period_at(step_index);
			else if (25'(step_index) + 25'(ramp_len) >= 25'(major_total))
				r.half_period = half_period_at(major_total - step_index);
			else
				r.half_period = HALF_BITS'(cruise_half);
			step_error = step_error - $signed({2'b00, minor_total});
			minor_hit = step_error < 0;
			if (minor_hit)
				step_error = step_error + $signed({2'b00, major_total});
			r.x_pulse = x_major | minor_hit;
			r.y_pulse = !x_major | minor_hit;
			if (r.x_pulse)
				x_count = x_fwd ? x_count + 1 : x_count - 1;
			if (r.y_pulse)
				y_count = y_fwd ? y_count + 1 : y_count - 1;
			step_index = step_index + 1;
			if (step_index >= major_total) begin
				move_active = 1'b0;
				r.last_step = 1'b1;
			end
		end
		r.x_dir = x_fwd;
		r.y_dir = y_fwd;
		r.x_position = x_count;
		r.y_position = y_count;
		return r;
	endfunction

	task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		step_result_t want;
		if (!arst_n) begin
			start_factor = START_FACTOR_RST;
			min_start = MIN_START_RST;
			move_active = 1'b0;
			x_major = 1'b0;
			major_total = '0;
			minor_total = '0;
			step_error = '0;
			step_index = '0;
			x_fwd = 1'b0;
			y_fwd = 1'b0;
			cruise_half = '0;
			start_half = '0;
			ramp_len = '0;
			x_count = '0;
			y_count = '0;
			pending_steps.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_FACTOR: start_factor = cfg_data[FACTOR_BITS-1:0];
					CFG_MIN_START:    min_start = cfg_data[DELAY_BITS-1:0];
					default: ;
				endcase
			end
			// results are matched before this edge's request is predicted
			if (out_valid && !out_stall) begin
				if (pending_steps.size() == 0) begin
					$display("%0t: result with no request waiting, expected none, got one",
						$time);
					errors++;
				end else begin
					want = pending_steps.pop_front();
					check_field("x_pulse", want.x_pulse, x_pulse);
					check_field("y_pulse", want.y_pulse, y_pulse);
					check_field("x_dir", want.x_dir, x_dir);
					check_field("y_dir", want.y_dir, y_dir);
					check_field("half_period", want.half_period, half_period);
					check_field("last_step", want.last_step, last_step);
					check_field("x_position", $signed(want.x_position), x_position);
					check_field("y_position", $signed(want.y_position), y_position);
					check_field("idle_error", want.idle_error, idle_error);
				end
			end
			if (in_valid && !in_stall)
				pending_steps.push_back(next_step_result(operation, x_move_steps,
					y_move_steps, cruise_delay, ramp_steps));
			outstanding <= pending_steps.size();
		end
	end

endmodule

@@ tb/sv/two_axis_linear_step_interpolator_tb.sv @@
module two_axis_linear_step_interpolator_tb;
	import tlsi_pkg::*;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0]           cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]            cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic                                operation = OP_LOAD;
	logic signed [MOVE_BITS-1:0]         x_move_steps = '0;
	logic signed [MOVE_BITS-1:0]         y_move_steps = '0;
	logic [DELAY_BITS-1:0]               cruise_delay = '0;
	logic [RAMP_BITS-1:0]                ramp_steps = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic                                x_pulse;
	logic                                y_pulse;
	logic                                x_dir;
	logic                                y_dir;
	logic [HALF_BITS-1:0]                half_period;
	logic                                last_step;
	logic signed [OUT_POS_BITS-1:0]      x_position;
	logic signed [OUT_POS_BITS-1:0]      y_position;
	logic                                idle_error;
	int                                  errors;
	int                                  outstanding;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int requests_sent = 0;
	int n_loads = 0;
	int n_advances = 0;
	int n_reg_writes = 0;

	two_axis_linear_step_interpolator i_dut (.*);

	step_move_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic issue_request(logic op, logic signed [MOVE_BITS-1:0] xs,
			logic signed [MOVE_BITS-1:0] ys, logic [DELAY_BITS-1:0] cruise,
			logic [RAMP_BITS-1:0] ramp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		x_move_steps <= xs;
		y_move_steps <= ys;
		cruise_delay <= cruise;
		ramp_steps <= ramp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
		if (op == OP_LOAD)
			n_loads++;
		else
			n_advances++;
	endtask

	task automatic load_move(logic signed [MOVE_BITS-1:0] xs, logic signed [MOVE_BITS-1:0] ys,
			logic [DELAY_BITS-1:0] cruise, logic [RAMP_BITS-1:0] ramp);
		issue_request(OP_LOAD, xs, ys, cruise, ramp);
	endtask

	// load-only fields carry noise on an advance
	task automatic advance_step();
		issue_request(OP_ADVANCE, MOVE_BITS'($urandom), MOVE_BITS'($urandom),
			DELAY_BITS'($urandom), RAMP_BITS'($urandom));
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		n_reg_writes++;
	endtask

	task automatic set_config(logic [FACTOR_BITS-1:0] factor, logic [DELAY_BITS-1:0] min_start);
		// upper data bits are don't-care for the factor register
		write_reg(CFG_START_FACTOR, {12'($urandom), factor});
		write_reg(CFG_MIN_START, min_start);
		cfg_we <= 1'b0;
	endtask

	task automatic random_traffic(int quota);
		int                          target;
		int                          pick;
		int                          xm;
		int                          ym;
		int                          major;
		int                          n;
		int                          extra;
		logic signed [MOVE_BITS-1:0] xs;
		logic signed [MOVE_BITS-1:0] ys;
		logic [DELAY_BITS-1:0]       cruise;
		logic [RAMP_BITS-1:0]        ramp;
		target = requests_sent + quota;
		while (requests_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 82) begin
				// short complete move, sometimes cut off or followed by idle advances
				xm = $urandom_range(0, 40);
				ym = $urandom_range(0, 40);
				if ($urandom_range(9) == 0)
					ym = xm;
				else if ($urandom_range(9) == 0)
					ym = 0;
				xs = $urandom_range(1) ? MOVE_BITS'(xm) : -MOVE_BITS'(xm);
				ys = $urandom_range(1) ? MOVE_BITS'(ym) : -MOVE_BITS'(ym);
				major = (xm >= ym) ? xm : ym;
				ramp = ($urandom_range(4) == 0) ? '0 : RAMP_BITS'($urandom_range(1, major + 3));
				cruise = $urandom_range(1) ? DELAY_BITS'($urandom)
					: DELAY_BITS'($urandom_range(0, 300));
				n = major;
				if ($urandom_range(6) == 0)
					n = $urandom_range(0, major);
				extra = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : 0;
				load_move(xs, ys, cruise, ramp);
				repeat (n + extra) advance_step();
			end else if (pick < 92) begin
				// full-range load, replaced soon by the next one
				load_move(MOVE_BITS'($urandom), MOVE_BITS'($urandom), DELAY_BITS'($urandom),
					RAMP_BITS'($urandom));
				repeat ($urandom_range(0, 3)) advance_step();
			end else begin
				advance_step();
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// advance with nothing loaded
		advance_step();
		// empty move
		load_move(25'sd0, 25'sd0, 16'd1234, 24'd5);
		advance_step();
		// largest counts, most negative y saturates, tie goes to x
		load_move(25'sd16777215, 25'h1000000, 16'hFFFF, 24'hFFFFFF);
		advance_step();
		advance_step();
		// new move replaces the running one; zero ramp and zero cruise
		load_move(-25'sd5, 25'sd3, 16'd0, 24'd0);
		repeat (5) advance_step();
		advance_step();
		// y dominant, ramp longer than the move
		load_move(25'sd2, -25'sd7, 16'd100, 24'd20);
		repeat (7) advance_step();
		// start below cruise
		quiesce();
		set_config(4'd0, 16'd0);
		load_move(25'sd3, 25'sd3, 16'd40000, 24'd2);
		repeat (3) advance_step();

		quiesce();
		set_config(4'd15, 16'hFFFF);
		random_traffic(445);

		quiesce();
		set_config(4'd1, 16'd0);
		send_idle_pct = 85;
		random_traffic(445);

		quiesce();
		set_config(FACTOR_BITS'($urandom), DELAY_BITS'($urandom_range(0, 2000)));
		send_idle_pct = 0;
		stall_pct = 85;
		random_traffic(445);

		quiesce();
		set_config(START_FACTOR_RST, MIN_START_RST);
		send_idle_pct = 21;
		stall_pct = 21;
		random_traffic(445);

		quiesce();
		$display("covered %0d load and %0d advance requests under four gap and stall mixes",
			n_loads, n_advances);
		$display("%0d register writes, start factor from 0 to 15, start floor from 0 to 65535",
			n_reg_writes);
		if (errors == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
